// File: hdl/cpvp_pkg.sv
// cpvp_pkg: shared types, constants and helper functions of the cascaded
// position/velocity pid block. Used by the controller, datapath and top
// level. No dependencies.
package cpvp_pkg;

  // field widths
  localparam int MOTOR_W   = 2;
  localparam int ANGLE_W   = 13;
  localparam int SPEED_W   = 16;
  localparam int TARGET_W  = 32;
  localparam int CUR_W     = 13;
  localparam int POS_W     = 32;
  localparam int ERR_W     = 16;
  localparam int DER_W     = 17;
  localparam int PINT_W    = 15;
  localparam int VINT_W    = 11;
  localparam int GAIN_W    = 16;

  localparam int S_TDATA_W = 80;
  localparam int M_TDATA_W = 64;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // shared multiplier: 33-bit signed value times 17-bit signed operand
  localparam int MUL_A_W   = 33;
  localparam int MUL_B_W   = 17;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int FRAC_BITS = 12;
  localparam int QT_W      = FRAC_BITS + ERR_W;

  // loop limits
  localparam logic signed [ERR_W-1:0] POS_DEADZONE = 16'sd10;
  localparam logic signed [ERR_W-1:0] ERR_TOL      = 16'sd50;
  localparam logic signed [ERR_W-1:0] SPEED_TOL    = 16'sd100;
  localparam logic signed [ERR_W-1:0] OUT_LIMIT    = 16'sd3000;
  localparam logic signed [DER_W-1:0] POS_ILIMIT   = 17'sd10000;
  localparam logic signed [DER_W-1:0] VEL_ILIMIT   = 17'sd1000;

  // gain reset values, unsigned q4.12
  localparam logic [GAIN_W-1:0] POS_KP_RST = 16'd8192;
  localparam logic [GAIN_W-1:0] POS_KI_RST = 16'd410;
  localparam logic [GAIN_W-1:0] POS_KD_RST = 16'd8192;
  localparam logic [GAIN_W-1:0] VEL_KP_RST = 16'd8192;
  localparam logic [GAIN_W-1:0] VEL_KI_RST = 16'd410;
  localparam logic [GAIN_W-1:0] VEL_KD_RST = 16'd2048;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_POS_KP = 3'd0,
    REG_POS_KI = 3'd1,
    REG_POS_KD = 3'd2,
    REG_VEL_KP = 3'd3,
    REG_VEL_KI = 3'd4,
    REG_VEL_KD = 3'd5
  } cfg_reg_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_UNWRAP,
    S_STEP,
    S_SCALE,
    S_DIV_LD,
    S_DIV,
    S_PERR,
    S_PPREP,
    S_PM_P,
    S_PM_I,
    S_PM_D,
    S_PACC,
    S_PSET,
    S_VERR,
    S_VPREP,
    S_VM_P,
    S_VM_I,
    S_VM_D,
    S_VACC,
    S_COMMIT,
    S_OUT
  } state_t;

  typedef enum logic [2:0] {
    MUL_SCALE,
    MUL_PP,
    MUL_PI,
    MUL_PD,
    MUL_VP,
    MUL_VI,
    MUL_VD
  } mul_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     unwrap;
    logic     step;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     acc_clr;
    logic     acc_en;
    logic     div_start;
    logic     perr_en;
    logic     pprep;
    logic     pset;
    logic     verr_en;
    logic     vprep;
    logic     commit;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic oor;
    logic skip;
    logic div_busy;
    logic out_free;
  } status_t;

  function automatic logic [ERR_W:0] abs16(input logic signed [ERR_W-1:0] v);
    logic signed [ERR_W:0] w;
    w = (ERR_W+1)'(v);
    return (v < 0) ? (ERR_W+1)'(-w) : (ERR_W+1)'(w);
  endfunction

  function automatic logic signed [DER_W-1:0] clamp17(input logic signed [DER_W-1:0] v,
                                                     input logic signed [DER_W-1:0] lim);
    logic signed [DER_W-1:0] r;
    if (v > lim) begin
      r = lim;
    end else if (v < -lim) begin
      r = -lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic signed [CUR_W-1:0] sat_out(input logic signed [ERR_W-1:0] v);
    logic signed [CUR_W-1:0] r;
    if (v > OUT_LIMIT) begin
      r = CUR_W'(OUT_LIMIT);
    end else if (v < -OUT_LIMIT) begin
      r = CUR_W'(-OUT_LIMIT);
    end else begin
      r = v[CUR_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: hdl/cpvp_cdiv.sv
// cpvp_cdiv: unsigned division by a constant power-of-two divisor, done as
// a registered right shift in the cycle after start. No dependencies.
module cpvp_cdiv #(
  parameter int NUM_W   = 42,
  parameter int DIVISOR = 8192
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] numer,
  output logic             busy,
  output logic [NUM_W-1:0] quot
);

  localparam int SHIFT = $clog2(DIVISOR);

  logic [NUM_W-1:0] numer_r;
  logic [NUM_W-1:0] q;
  logic             pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= start;
    end
  end

  // numerator captured on start, quotient formed in the following cycle
  always_ff @(posedge clk) begin
    if (start) begin
      numer_r <= numer;
    end
    if (pend) begin
      q <= numer_r >> SHIFT;
    end
  end

  assign busy = pend;
  assign quot = q;

endmodule

// File: hdl/cpvp_dp.sv
// cpvp_dp: datapath of the cascaded pid: input and output registers, gain
// registers, per-motor state, shared multiplier, accumulator and divider.
// Depends on cpvp_pkg and cpvp_cdiv.
module cpvp_dp #(
  parameter int MOTORS         = 4,
  parameter int ENCODER_COUNTS = 8192,
  parameter int POSITION_SCALE = 100
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  cpvp_pkg::cmd_t                       cmd,
  output cpvp_pkg::status_t                    st,
  input  logic [cpvp_pkg::MOTOR_W-1:0]         in_motor,
  input  logic [cpvp_pkg::ANGLE_W-1:0]         in_angle,
  input  logic [cpvp_pkg::ANGLE_W-1:0]         in_prev,
  input  logic signed [cpvp_pkg::SPEED_W-1:0]  in_speed,
  input  logic signed [cpvp_pkg::TARGET_W-1:0] in_target,
  input  logic                                 cfg_we,
  input  logic [cpvp_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [cpvp_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic [cpvp_pkg::MOTOR_W-1:0]         out_motor,
  output logic signed [cpvp_pkg::CUR_W-1:0]    out_drive,
  output logic signed [cpvp_pkg::CUR_W-1:0]    out_vset,
  output logic signed [cpvp_pkg::POS_W-1:0]    out_scaled,
  output logic                                 out_at
);

  localparam int MIDX_W = (MOTORS > 1) ? $clog2(MOTORS) : 1;
  localparam int NUM_W  = cpvp_pkg::POS_W + $clog2(POSITION_SCALE + 1);
  localparam logic signed [17:0] ENC_S = 18'(ENCODER_COUNTS);
  localparam logic [cpvp_pkg::QT_W-1:0] FRAC_MASK =
    cpvp_pkg::QT_W'((1 << cpvp_pkg::FRAC_BITS) - 1);

  // gains
  logic [cpvp_pkg::GAIN_W-1:0] pos_kp, pos_ki, pos_kd, vel_kp, vel_ki, vel_kd;

  // per-motor state
  logic signed [cpvp_pkg::POS_W-1:0]  pos_count [MOTORS];
  logic signed [cpvp_pkg::PINT_W-1:0] pos_int   [MOTORS];
  logic signed [cpvp_pkg::ERR_W-1:0]  pos_last  [MOTORS];
  logic signed [cpvp_pkg::VINT_W-1:0] vel_int   [MOTORS];
  logic signed [cpvp_pkg::ERR_W-1:0]  vel_last  [MOTORS];

  // item registers
  logic [cpvp_pkg::MOTOR_W-1:0]         motor_r;
  logic [cpvp_pkg::ANGLE_W-1:0]         angle_r;
  logic [cpvp_pkg::ANGLE_W-1:0]         prev_r;
  logic signed [cpvp_pkg::SPEED_W-1:0]  speed_r;
  logic signed [cpvp_pkg::TARGET_W-1:0] target_r;
  logic signed [cpvp_pkg::ERR_W-1:0]    diff_r;
  logic signed [cpvp_pkg::POS_W-1:0]    pc_new;
  logic signed [cpvp_pkg::PROD_W-1:0]   prod;
  logic                                 neg_r;
  logic signed [cpvp_pkg::POS_W-1:0]    scaled_r;
  logic signed [cpvp_pkg::ERR_W-1:0]    perr_r;
  logic                                 skip_r;
  logic                                 at_r;
  logic signed [cpvp_pkg::PINT_W-1:0]   pint_new;
  logic signed [cpvp_pkg::DER_W-1:0]    pder;
  logic signed [cpvp_pkg::CUR_W-1:0]    vset_r;
  logic signed [cpvp_pkg::ERR_W-1:0]    verr_r;
  logic signed [cpvp_pkg::VINT_W-1:0]   vint_new;
  logic signed [cpvp_pkg::DER_W-1:0]    vder;
  logic signed [cpvp_pkg::ERR_W-1:0]    acc;
  logic signed [cpvp_pkg::CUR_W-1:0]    drive_r;

  logic [MIDX_W-1:0] idx;

  // combinational helpers
  logic signed [cpvp_pkg::ERR_W-1:0]   diff_raw;
  logic signed [17:0]                  diff_ext;
  logic signed [cpvp_pkg::ERR_W-1:0]   diff_alt;
  logic signed [cpvp_pkg::ERR_W-1:0]   diff_sel;
  logic signed [cpvp_pkg::MUL_A_W-1:0] mul_a;
  logic signed [cpvp_pkg::MUL_B_W-1:0] mul_b;
  logic [cpvp_pkg::QT_W-1:0]           qt;
  logic signed [cpvp_pkg::ERR_W-1:0]   q16;
  logic signed [cpvp_pkg::PROD_W-1:0]  prod_mag;
  logic [NUM_W-1:0]                    div_quot;
  logic                                div_busy;
  logic [cpvp_pkg::POS_W-1:0]          q32;
  logic signed [cpvp_pkg::POS_W-1:0]   scaled_val;
  logic signed [cpvp_pkg::ERR_W-1:0]   perr_val;
  logic signed [cpvp_pkg::DER_W-1:0]   pint_sum;
  logic signed [cpvp_pkg::DER_W-1:0]   vint_sum;

  assign idx = MIDX_W'(motor_r);

  cpvp_cdiv #(
    .NUM_W   (NUM_W),
    .DIVISOR (ENCODER_COUNTS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .numer (prod_mag[NUM_W-1:0]),
    .busy  (div_busy),
    .quot  (div_quot)
  );

  // angle unwrap: take the shorter way round
  always_comb begin
    diff_raw = cpvp_pkg::ERR_W'(angle_r) - cpvp_pkg::ERR_W'(prev_r);
    diff_ext = 18'(diff_raw);
    if (diff_raw > 0) begin
      diff_alt = cpvp_pkg::ERR_W'(diff_ext - ENC_S);
    end else begin
      diff_alt = cpvp_pkg::ERR_W'(diff_ext + ENC_S);
    end
    if (cpvp_pkg::abs16(diff_alt) < cpvp_pkg::abs16(diff_raw)) begin
      diff_sel = diff_alt;
    end else begin
      diff_sel = diff_raw;
    end
  end

  // multiplier operand select
  always_comb begin
    case (cmd.mul_sel)
      cpvp_pkg::MUL_SCALE: begin
        mul_a = cpvp_pkg::MUL_A_W'(pc_new);
        mul_b = cpvp_pkg::MUL_B_W'(POSITION_SCALE);
      end
      cpvp_pkg::MUL_PP: begin
        mul_a = cpvp_pkg::MUL_A_W'(perr_r);
        mul_b = signed'({1'b0, pos_kp});
      end
      cpvp_pkg::MUL_PI: begin
        mul_a = cpvp_pkg::MUL_A_W'(pint_new);
        mul_b = signed'({1'b0, pos_ki});
      end
      cpvp_pkg::MUL_PD: begin
        mul_a = cpvp_pkg::MUL_A_W'(pder);
        mul_b = signed'({1'b0, pos_kd});
      end
      cpvp_pkg::MUL_VP: begin
        mul_a = cpvp_pkg::MUL_A_W'(verr_r);
        mul_b = signed'({1'b0, vel_kp});
      end
      cpvp_pkg::MUL_VI: begin
        mul_a = cpvp_pkg::MUL_A_W'(vint_new);
        mul_b = signed'({1'b0, vel_ki});
      end
      cpvp_pkg::MUL_VD: begin
        mul_a = cpvp_pkg::MUL_A_W'(vder);
        mul_b = signed'({1'b0, vel_kd});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // product / 4096 toward zero; only the low 16 bits survive the wrap
  always_comb begin
    qt  = prod[cpvp_pkg::QT_W-1:0] + (prod[cpvp_pkg::PROD_W-1] ? FRAC_MASK : '0);
    q16 = qt[cpvp_pkg::QT_W-1:cpvp_pkg::FRAC_BITS];
  end

  always_comb begin
    prod_mag   = prod[cpvp_pkg::PROD_W-1] ? -prod : prod;
    q32        = div_quot[cpvp_pkg::POS_W-1:0];
    scaled_val = neg_r ? -signed'(q32) : signed'(q32);
    perr_val   = target_r[cpvp_pkg::ERR_W-1:0] - scaled_val[cpvp_pkg::ERR_W-1:0];
    pint_sum   = cpvp_pkg::DER_W'(pos_int[idx]) + cpvp_pkg::DER_W'(perr_r);
    vint_sum   = cpvp_pkg::DER_W'(vel_int[idx]) + cpvp_pkg::DER_W'(verr_r);
  end

  // gain registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_kp <= cpvp_pkg::POS_KP_RST;
      pos_ki <= cpvp_pkg::POS_KI_RST;
      pos_kd <= cpvp_pkg::POS_KD_RST;
      vel_kp <= cpvp_pkg::VEL_KP_RST;
      vel_ki <= cpvp_pkg::VEL_KI_RST;
      vel_kd <= cpvp_pkg::VEL_KD_RST;
    end else if (cfg_we) begin
      case (cpvp_pkg::cfg_reg_t'(cfg_index))
        cpvp_pkg::REG_POS_KP: pos_kp <= cfg_data;
        cpvp_pkg::REG_POS_KI: pos_ki <= cfg_data;
        cpvp_pkg::REG_POS_KD: pos_kd <= cfg_data;
        cpvp_pkg::REG_VEL_KP: vel_kp <= cfg_data;
        cpvp_pkg::REG_VEL_KI: vel_ki <= cfg_data;
        cpvp_pkg::REG_VEL_KD: vel_kd <= cfg_data;
        default: ;
      endcase
    end
  end

  // per-motor state, written once the item is complete
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MOTORS; i++) begin
        pos_count[i] <= '0;
        pos_int[i]   <= '0;
        pos_last[i]  <= '0;
        vel_int[i]   <= '0;
        vel_last[i]  <= '0;
      end
    end else if (cmd.commit) begin
      pos_count[idx] <= pc_new;
      if (!skip_r) begin
        pos_int[idx]  <= pint_new;
        pos_last[idx] <= perr_r;
      end
      vel_int[idx]  <= vint_new;
      vel_last[idx] <= verr_r;
    end
  end

  // item datapath registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      motor_r  <= in_motor;
      angle_r  <= in_angle;
      prev_r   <= in_prev;
      speed_r  <= in_speed;
      target_r <= in_target;
    end
    if (cmd.unwrap) begin
      diff_r <= diff_sel;
    end
    if (cmd.step) begin
      pc_new <= pos_count[idx] + cpvp_pkg::POS_W'(diff_r);
    end
    if (cmd.mul_en) begin
      prod <= cpvp_pkg::PROD_W'(mul_a) * cpvp_pkg::PROD_W'(mul_b);
    end
    if (cmd.div_start) begin
      neg_r <= prod[cpvp_pkg::PROD_W-1];
    end
    if (cmd.perr_en) begin
      perr_r <= perr_val;
      skip_r <= (perr_val > -cpvp_pkg::POS_DEADZONE) && (perr_val < cpvp_pkg::POS_DEADZONE);
    end
    if (cmd.pprep) begin
      pint_new <= cpvp_pkg::PINT_W'(cpvp_pkg::clamp17(pint_sum, cpvp_pkg::POS_ILIMIT));
      pder     <= cpvp_pkg::DER_W'(perr_r) - cpvp_pkg::DER_W'(pos_last[idx]);
    end
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (cmd.acc_en) begin
      acc <= acc + q16;
    end
    if (cmd.verr_en) begin
      verr_r <= cpvp_pkg::ERR_W'(cpvp_pkg::DER_W'(vset_r) - cpvp_pkg::DER_W'(speed_r));
    end
    if (cmd.vprep) begin
      vint_new <= cpvp_pkg::VINT_W'(cpvp_pkg::clamp17(vint_sum, cpvp_pkg::VEL_ILIMIT));
      vder     <= cpvp_pkg::DER_W'(verr_r) - cpvp_pkg::DER_W'(vel_last[idx]);
    end
  end

  // result fields: cleared per item so out-of-range motors read zero and vset reads zero in the deadzone
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      scaled_r <= '0;
      at_r     <= 1'b0;
      vset_r   <= '0;
      drive_r  <= '0;
    end else begin
      if (cmd.perr_en) begin
        scaled_r <= scaled_val;
        at_r     <= (perr_val >= -cpvp_pkg::ERR_TOL) && (perr_val <= cpvp_pkg::ERR_TOL) &&
                    (speed_r >= -cpvp_pkg::SPEED_TOL) && (speed_r <= cpvp_pkg::SPEED_TOL);
      end
      if (cmd.pset) begin
        vset_r <= cpvp_pkg::sat_out(acc);
      end
      if (cmd.commit) begin
        drive_r <= cpvp_pkg::sat_out(acc);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_motor  <= motor_r;
      out_drive  <= drive_r;
      out_vset   <= vset_r;
      out_scaled <= scaled_r;
      out_at     <= at_r;
    end
  end

  assign st.oor      = (32'(motor_r) >= 32'(MOTORS));
  assign st.skip     = skip_r;
  assign st.div_busy = div_busy;
  assign st.out_free = !out_valid || out_ready;

endmodule

// File: hdl/cpvp_ctrl.sv
// cpvp_ctrl: sequencer of the cascaded pid, one item at a time through
// unwrap, scaling, position loop, velocity loop and output. Depends on cpvp_pkg.
module cpvp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  cpvp_pkg::status_t   st,
  output cpvp_pkg::cmd_t      cmd
);

  cpvp_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cpvp_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.mul_sel = cpvp_pkg::MUL_SCALE;
    in_ready    = 1'b0;
    case (state)
      cpvp_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = cpvp_pkg::S_UNWRAP;
        end
      end
      cpvp_pkg::S_UNWRAP: begin
        cmd.unwrap = 1'b1;
        state_next = st.oor ? cpvp_pkg::S_OUT : cpvp_pkg::S_STEP;
      end
      cpvp_pkg::S_STEP: begin
        cmd.step   = 1'b1;
        state_next = cpvp_pkg::S_SCALE;
      end
      cpvp_pkg::S_SCALE: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = cpvp_pkg::MUL_SCALE;
        state_next  = cpvp_pkg::S_DIV_LD;
      end
      cpvp_pkg::S_DIV_LD: begin
        cmd.div_start = 1'b1;
        state_next    = cpvp_pkg::S_DIV;
      end
      cpvp_pkg::S_DIV: begin
        if (!st.div_busy) begin
          state_next = cpvp_pkg::S_PERR;
        end
      end
      cpvp_pkg::S_PERR: begin
        cmd.perr_en = 1'b1;
        state_next  = cpvp_pkg::S_PPREP;
      end
      cpvp_pkg::S_PPREP: begin
        cmd.pprep  = 1'b1;
        // inside the deadzone the position loop is bypassed
        state_next = st.skip ? cpvp_pkg::S_VERR : cpvp_pkg::S_PM_P;
      end
      cpvp_pkg::S_PM_P: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = cpvp_pkg::MUL_PP;
        cmd.acc_clr = 1'b1;
        state_next  = cpvp_pkg::S_PM_I;
      end
      cpvp_pkg::S_PM_I: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = cpvp_pkg::MUL_PI;
        cmd.acc_en  = 1'b1;
        state_next  = cpvp_pkg::S_PM_D;
      end
      cpvp_pkg::S_PM_D: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = cpvp_pkg::MUL_PD;
        cmd.acc_en  = 1'b1;
        state_next  = cpvp_pkg::S_PACC;
      end
      cpvp_pkg::S_PACC: begin
        cmd.acc_en = 1'b1;
        state_next = cpvp_pkg::S_PSET;
      end
      cpvp_pkg::S_PSET: begin
        cmd.pset   = 1'b1;
        state_next = cpvp_pkg::S_VERR;
      end
      cpvp_pkg::S_VERR: begin
        cmd.verr_en = 1'b1;
        state_next  = cpvp_pkg::S_VPREP;
      end
      cpvp_pkg::S_VPREP: begin
        cmd.vprep  = 1'b1;
        state_next = cpvp_pkg::S_VM_P;
      end
      cpvp_pkg::S_VM_P: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = cpvp_pkg::MUL_VP;
        cmd.acc_clr = 1'b1;
        state_next  = cpvp_pkg::S_VM_I;
      end
      cpvp_pkg::S_VM_I: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = cpvp_pkg::MUL_VI;
        cmd.acc_en  = 1'b1;
        state_next  = cpvp_pkg::S_VM_D;
      end
      cpvp_pkg::S_VM_D: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = cpvp_pkg::MUL_VD;
        cmd.acc_en  = 1'b1;
        state_next  = cpvp_pkg::S_VACC;
      end
      cpvp_pkg::S_VACC: begin
        cmd.acc_en = 1'b1;
        state_next = cpvp_pkg::S_COMMIT;
      end
      cpvp_pkg::S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = cpvp_pkg::S_OUT;
      end
      cpvp_pkg::S_OUT: begin
        // wait here while the previous result is still unclaimed
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = cpvp_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = cpvp_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/cascaded_position_velocity_pid_top.sv
// cascaded_position_velocity_pid_top: top level of the cascaded
// position/velocity pid. Depends on cpvp_pkg, cpvp_ctrl and cpvp_dp.
//
// Usage:
//   s_* carries one motor sample per transfer; m_* returns one result per
//   sample in the same order. cfg_we/cfg_index/cfg_data write the six gains
//   (index 0..5: pos_kp, pos_ki, pos_kd, vel_kp, vel_ki, vel_kd); other
//   indexes are ignored. Write gains only while the block is idle.
//   Items are handled one at a time by a sequencer that shares one 33x17
//   multiplier over six gain products and the position scaling; the divide
//   by ENCODER_COUNTS (a power of two) is a registered shift. An item whose
//   position error falls in the deadzone skips the position loop, and one
//   with a motor index at or beyond MOTORS goes straight to the output.
//   A result waiting on m_tready does not block the next input transfer;
//   only a second finished result stalls the sequencer until the output
//   register frees up. Reset (rst, synchronous) clears all per-motor state,
//   restores the gain defaults and drops m_tvalid.
module cascaded_position_velocity_pid_top #(
  parameter int MOTORS         = 4,
  parameter int ENCODER_COUNTS = 8192,
  parameter int POSITION_SCALE = 100
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // motor_index[1:0], encoder_angle[14:2], previous_angle[27:15],
  // speed[43:28], position_target[75:44], zero pad[79:76]
  input  logic [cpvp_pkg::S_TDATA_W-1:0]      s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // motor[1:0], drive_current[14:2], velocity_setpoint[27:15],
  // scaled_position[59:28], at_target[60], zero pad[63:61]
  output logic [cpvp_pkg::M_TDATA_W-1:0]      m_tdata,
  input  logic                                cfg_we,
  input  logic [cpvp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [cpvp_pkg::CFG_DATA_W-1:0]     cfg_data
);

  cpvp_pkg::cmd_t    cmd;
  cpvp_pkg::status_t st;

  logic [cpvp_pkg::MOTOR_W-1:0]      out_motor;
  logic signed [cpvp_pkg::CUR_W-1:0] out_drive;
  logic signed [cpvp_pkg::CUR_W-1:0] out_vset;
  logic signed [cpvp_pkg::POS_W-1:0] out_scaled;
  logic                              out_at;

  cpvp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  cpvp_dp #(
    .MOTORS         (MOTORS),
    .ENCODER_COUNTS (ENCODER_COUNTS),
    .POSITION_SCALE (POSITION_SCALE)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .in_motor   (s_tdata[1:0]),
    .in_angle   (s_tdata[14:2]),
    .in_prev    (s_tdata[27:15]),
    .in_speed   (s_tdata[43:28]),
    .in_target  (s_tdata[75:44]),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .out_motor  (out_motor),
    .out_drive  (out_drive),
    .out_vset   (out_vset),
    .out_scaled (out_scaled),
    .out_at     (out_at)
  );

  assign m_tdata = {3'b000, out_at, out_scaled, out_vset, out_drive, out_motor};

endmodule
